// ===== hdl/mavg_pkg.sv =====
// Shared types and constants for the moving average window core.
package mavg_pkg;

  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd50;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUB  = 7'b0000010,
    S_ADD  = 7'b0000100,
    S_ABS  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIX  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

endpackage

// ===== hdl/moving_average_window_core.sv =====
// Moving average over a ring of signed fixed-point samples.
//
// Input channel (in_valid_i / in_stall_o): each beat is either a sample
// (in_kind_i = 0) or an end-of-data request (in_kind_i = 1). A sample beat
// produces no result; an end beat produces exactly one output beat with the
// truncated mean of the last window samples, or status 1 if fewer samples
// than the window were seen. Count, sum and ring index clear after each end.
// Steps: a sample is accepted, then the oldest drops out (once the window is
// full) and the newest is added, both on the one shared adder. An end beat
// with enough samples runs abs, SUM_W restoring divide steps on the same
// adder, sign fix and output load; a short-window end goes straight to load.
// Output channel (out_valid_o / out_stall_i): the result sits in an output
// register; while it is stalled the core keeps accepting sample beats and
// holds a new result, with its input stalled, until the register frees.
// cfg_we_i writes window_length (0 acts as 1, above WINDOW_MAX clamps) and
// restarts the run. Reset clears the run and sets window_length to 50; the
// ring memory is not cleared since only written entries are ever read.
module moving_average_window_core import mavg_pkg::*; #(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   in_kind_i,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] out_average_o,
  output logic                   out_status_o
);

  localparam int unsigned WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + WIN_W;
  localparam int unsigned EW    = (WIN_W > CFG_W) ? WIN_W : CFG_W;
  localparam int unsigned CNT_W = $clog2(SUM_W);

  state_e state_q, state_d;

  logic [CFG_W-1:0]       win_len_q;
  logic [WIN_W-1:0]       win;
  logic [EW-1:0]          wl_ext;
  logic [IDX_W-1:0]       wr_idx_q;
  logic [WIN_W-1:0]       filled_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0] samp_q;
  logic [SUM_W-1:0]       quo_q;
  logic [WIN_W-1:0]       rem_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   neg_q;
  logic                   stat_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_avg_q;
  logic                   out_stat_q;

  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SUM_W-1:0]       alu_a, alu_b, alu_y;
  alu_op_e                alu_op;
  logic                   alu_neg;
  logic [WIN_W:0]         rem_sh;
  logic [WIN_W:0]         idx_inc;
  logic                   in_acc, full, out_free;

  // Effective window: zero acts as one, clamp to ring depth.
  always_comb begin
    wl_ext = EW'(win_len_q);
    if (wl_ext == '0) begin
      wl_ext = EW'(1);
    end else if (wl_ext > EW'(WINDOW_MAX)) begin
      wl_ext = EW'(WINDOW_MAX);
    end
    win = wl_ext[WIN_W-1:0];
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign full       = (filled_q >= win);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rem_sh     = {rem_q, quo_q[SUM_W-1]};
  assign idx_inc    = (WIN_W + 1)'(wr_idx_q) + (WIN_W + 1)'(1);

  mavg_ring #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (SAMPLE_BITS),
    .AW    (IDX_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SUB),
    .waddr_i (wr_idx_q),
    .wdata_i (samp_q),
    .raddr_i (wr_idx_q),
    .rdata_o (rd_data)
  );

  // Operand select for the shared adder.
  always_comb begin
    alu_a  = sum_q;
    alu_b  = '0;
    alu_op = ALU_ADD;
    case (state_q)
      S_SUB: begin
        alu_b  = {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
        alu_op = ALU_SUB;
      end
      S_ADD: begin
        alu_b  = {{(SUM_W-SAMPLE_BITS){samp_q[SAMPLE_BITS-1]}}, samp_q};
        alu_op = ALU_ADD;
      end
      S_ABS: begin
        alu_a  = '0;
        alu_b  = sum_q;
        alu_op = ALU_SUB;
      end
      S_DIV: begin
        alu_a  = SUM_W'(rem_sh);
        alu_b  = SUM_W'(win);
        alu_op = ALU_SUB;
      end
      S_FIX: begin
        alu_a  = '0;
        alu_b  = quo_q;
        alu_op = ALU_SUB;
      end
      default: begin
        alu_a  = sum_q;
        alu_b  = '0;
        alu_op = ALU_ADD;
      end
    endcase
  end

  mavg_alu #(.W(SUM_W)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .y_o   (alu_y),
    .neg_o (alu_neg)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_kind_i) state_d = S_SUB;
          else if (!full) state_d = S_OUT;
          else            state_d = S_ABS;
        end
      end
      S_SUB:   state_d = S_ADD;
      S_ADD:   state_d = S_IDLE;
      S_ABS:   state_d = S_DIV;
      S_DIV:   if (cnt_q == CNT_W'(SUM_W - 1)) state_d = S_FIX;
      S_FIX:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_len_q   <= CFG_RESET;
      wr_idx_q    <= '0;
      filled_q    <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
        wr_idx_q  <= '0;
        filled_q  <= '0;
        sum_q     <= '0;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (in_acc && in_kind_i && !full) begin
              wr_idx_q <= '0;
              filled_q <= '0;
              sum_q    <= '0;
            end
          end
          S_SUB: begin
            if (full) sum_q <= alu_y;
            else      filled_q <= filled_q + WIN_W'(1);
          end
          S_ADD: begin
            sum_q    <= alu_y;
            wr_idx_q <= (idx_inc >= (WIN_W + 1)'(win)) ? '0 : idx_inc[IDX_W-1:0];
          end
          S_ABS: begin
            wr_idx_q <= '0;
            filled_q <= '0;
            sum_q    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          samp_q <= in_sample_i;
          quo_q  <= '0;
          stat_q <= 1'b1;
        end
      end
      S_ABS: begin
        neg_q  <= sum_q[SUM_W-1];
        quo_q  <= sum_q[SUM_W-1] ? alu_y : sum_q;
        rem_q  <= '0;
        cnt_q  <= '0;
        stat_q <= 1'b0;
      end
      S_DIV: begin
        // restoring step: keep the difference when it did not go negative
        if (!alu_neg) begin
          rem_q <= alu_y[WIN_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[WIN_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      S_FIX: begin
        if (neg_q) quo_q <= alu_y;
      end
      S_OUT: begin
        if (out_free) begin
          out_avg_q  <= quo_q[SAMPLE_BITS-1:0];
          out_stat_q <= stat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_average_o = out_avg_q;
  assign out_status_o  = out_stat_q;

endmodule

// ===== hdl/mavg_alu.sv =====
// Shared add/subtract unit used for sum updates, negation and divide steps.
module mavg_alu import mavg_pkg::*; #(
  parameter int unsigned W = 43
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  alu_op_e      op_i,
  output logic [W-1:0] y_o,
  output logic         neg_o
);

  always_comb begin
    case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i + b_i;
    endcase
    neg_o = y_o[W-1];
  end

endmodule

// ===== hdl/mavg_ring.sv =====
// Sample ring memory: one write port, one registered read port.
module mavg_ring #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mavg_checker.sv =====
// Port-level checks for the moving average core, bound to the top level.
module mavg_checker #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   in_kind_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] out_average_o,
  input logic                   out_status_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_average_o)
      && $stable(out_status_o))
    else $error("stalled output beat changed");

  // every accepted beat leaves the core busy in the cycle after it
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("core ready right after accept");

  // a sample beat never produces a result
  a_no_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_kind_i && !out_valid_o |=> !out_valid_o)
    else $error("result after sample beat");

  // short-window status carries a zero average
  a_stat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o |-> out_average_o == '0)
    else $error("nonzero average with status set");

endmodule

bind moving_average_window_core mavg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mavg_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the moving average window core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mavg_pkg::CFG_W;
  import mavg_pkg::CFG_RESET;

  localparam int unsigned WIN_MAX    = 1024;
  localparam int unsigned SMP_W      = 32;
  localparam int unsigned SUM_W      = 42;
  localparam int unsigned SETTLE_CYC = 80;    // covers the divide path of an end beat
  localparam int unsigned HOLD_CYC   = 300;
  localparam int unsigned WDOG_LIMIT = 5000;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam int unsigned RAND_ITEMS = 150;
  localparam int unsigned RAND_MEANS = 10;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_END    = 1'b1
  } beat_kind_e;

  typedef enum logic {
    ST_VALID = 1'b0,
    ST_SHORT = 1'b1
  } mean_status_e;

  typedef struct packed {
    logic [SMP_W-1:0] average;
    mean_status_e     status;
  } mean_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             in_kind_i;
  logic [SMP_W-1:0] in_sample_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [SMP_W-1:0] out_average_o;
  logic             out_status_o;

  moving_average_window_core #(
    .WINDOW_MAX (WIN_MAX),
    .SAMPLE_BITS(SMP_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_kind_i    (in_kind_i),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_average_o(out_average_o),
    .out_status_o (out_status_o)
  );

  // Window model state
  logic signed [SMP_W-1:0] ring_m [WIN_MAX];
  logic [9:0]              wr_idx_m;
  logic [10:0]             fill_m;
  logic signed [SUM_W-1:0] sum_m;
  logic [CFG_W-1:0]        win_reg_m;
  mean_result_t            mean_expect_q [$];

  bit          jitter_on;
  bit          hold_go;
  int unsigned hold_left;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_cfg;
  int unsigned n_mismatch;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_window();
    int unsigned w;
    w = win_reg_m;
    if (w < 1) w = 1;
    if (w > WIN_MAX) w = WIN_MAX;
    return w;
  endfunction

  task automatic clear_window_run();
    wr_idx_m = '0;
    fill_m   = '0;
    sum_m    = '0;
  endtask

  task automatic advance_average(beat_kind_e kind, logic [SMP_W-1:0] smp);
    int unsigned  w;
    int unsigned  slot;
    longint       quo;
    mean_result_t r;
    w = active_window();
    if (kind == KIND_SAMPLE) begin
      slot = wr_idx_m;
      if (slot >= w) slot = 0;
      // once full, the slot being overwritten leaves the sum
      if (fill_m >= w) sum_m = sum_m - ring_m[slot];
      else fill_m++;
      ring_m[slot] = smp;
      sum_m = sum_m + $signed(smp);
      slot++;
      wr_idx_m = (slot >= w) ? '0 : slot[9:0];
    end else begin
      if (fill_m < w) begin
        r.average = '0;
        r.status  = ST_SHORT;
      end else begin
        quo = longint'(sum_m) / longint'(w);   // truncates toward zero
        r.average = quo[SMP_W-1:0];
        r.status  = ST_VALID;
      end
      mean_expect_q.push_back(r);
      clear_window_run();
    end
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);   // near +-1.0
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(beat_kind_e kind, logic [SMP_W-1:0] smp);
    while (jitter_on && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_kind_i   <= kind;
    in_sample_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_items++;
    advance_average(kind, smp);
  endtask

  task automatic send_samples(int unsigned n);
    repeat (n) send_beat(KIND_SAMPLE, rand_sample());
  endtask

  task automatic send_end();
    send_beat(KIND_END, $urandom);
  endtask

  // Drain results, then give the core time to finish any sample still in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (mean_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_window(logic [CFG_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_reg_m = value;
    clear_window_run();
    n_cfg++;
  endtask

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_CYC;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= jitter_on && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk_i) begin : result_check
    mean_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (mean_expect_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_SHOWN)
          $display("%0t: unexpected result beat: average %h status %0d",
                   $realtime, out_average_o, out_status_o);
      end else begin
        want = mean_expect_q.pop_front();
        if (out_average_o !== want.average || out_status_o !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= MAX_SHOWN)
            $display("%0t: result mismatch: average exp %h got %h, status exp %0d got %0d",
                     $realtime, want.average, out_average_o, want.status, out_status_o);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat moved for %0d cycles", WDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Default window of 50 straight out of reset.
  task automatic test_reset_window();
    send_samples(49);
    send_end();
    jitter_on = 1'b0;                            // stretch with no idling
    send_samples(53);
    send_end();
    jitter_on = 1'b1;
  endtask

  task automatic test_directed_edges();
    set_window(11'd1);
    send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
    send_end();
    send_beat(KIND_SAMPLE, 32'h8000_0000);
    send_end();
    send_end();                                  // no samples at all
    set_window(11'd0);                           // acts as one
    send_beat(KIND_SAMPLE, 32'h0000_0001);
    send_beat(KIND_SAMPLE, 32'h8000_0000);
    send_end();
    set_window(11'd2);
    send_beat(KIND_SAMPLE, 32'h8000_0000);
    send_beat(KIND_SAMPLE, 32'h8000_0001);
    send_end();
    send_beat(KIND_SAMPLE, 32'hFFFF_FFFD);       // -3 / 2 rounds toward zero
    send_beat(KIND_SAMPLE, 32'h0000_0000);
    send_end();
    send_beat(KIND_SAMPLE, 32'h0001_0000);
    send_end();                                  // one short of the window
    set_window(11'd3);
    send_beat(KIND_SAMPLE, 32'hFFFF_FFFF);
    send_beat(KIND_SAMPLE, 32'hFFFF_FFFF);
    send_beat(KIND_SAMPLE, 32'h0000_0000);
    send_end();
    repeat (3) send_beat(KIND_SAMPLE, 32'h7FFF_FFFF);
    send_end();
  endtask

  // A window write in the middle of a run restarts it.
  task automatic test_midstream_write();
    set_window(11'd4);
    send_samples(3);
    set_window(11'd4);
    send_samples(4);
    send_end();
    send_samples(6);
    set_window(11'd5);
    send_samples(5);
    send_end();
  endtask

  task automatic test_max_window();
    set_window(11'h7FF);                         // clamps to the maximum
    send_samples(20);
    send_end();
    set_window(11'd1024);
    send_samples(20);
    send_end();
  endtask

  // Long output hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    set_window(11'd2);
    hold_go = 1'b1;
    repeat (15) begin
      send_samples($urandom_range(2, 4));
      send_end();
    end
  endtask

  task automatic test_random_stream();
    int unsigned      items0;
    int unsigned      ends;
    int unsigned      iter;
    int unsigned      eff;
    int unsigned      pick;
    logic [CFG_W-1:0] w;
    items0 = n_items;
    ends   = 0;
    iter   = 0;
    while (n_items - items0 < RAND_ITEMS || ends < RAND_MEANS) begin
      jitter_on = !(iter >= 1 && iter < 3);      // stretch with no idling
      pick = $urandom_range(0, 99);
      if (pick < 70)      w = CFG_W'($urandom_range(1, 8));
      else if (pick < 85) w = CFG_W'($urandom_range(9, 64));
      else if (pick < 92) w = '0;
      else                w = CFG_W'($urandom_range(65, 2047));
      set_window(w);
      eff = active_window();
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        if (eff <= 64 && pick < 80) begin
          send_samples(eff + $urandom_range(0, 2 * eff));
          send_end();
          ends++;
        end else if (pick < 92 || eff > 64) begin
          send_samples($urandom_range(0, (eff > 20) ? 20 : eff - 1));
          send_end();
          ends++;
        end else begin
          // noise: arbitrary kinds, may leave a run open for the next write
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) == 0) begin
              send_beat(KIND_END, $urandom);
              ends++;
            end else begin
              send_beat(KIND_SAMPLE, rand_sample());
            end
          end
        end
      end
      iter++;
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_kind_i   = KIND_SAMPLE;
    in_sample_i = '0;
    out_stall_i = 1'b0;
    jitter_on   = 1'b1;
    hold_go     = 1'b0;
    hold_left   = 0;
    n_items     = 0;
    n_results   = 0;
    n_cfg       = 0;
    n_mismatch  = 0;
    win_reg_m   = CFG_RESET;
    clear_window_run();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_directed_edges();
    test_midstream_write();
    test_max_window();
    test_backpressure();
    test_random_stream();
    settle();

    $display("run: %0d input beats, %0d results checked, %0d window writes, %0d mismatches",
             n_items, n_results, n_cfg, n_mismatch);
    $display("windows from 0 to 2047, short and full runs, extreme samples, %0d-cycle hold",
             HOLD_CYC);
    if (n_mismatch == 0 && mean_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
